// File: rtl/tcbb_pkg.sv
// Shared constants, types and state encodings for the two-choice bucket balancer.
`timescale 1ns / 1ps
`default_nettype none
package tcbb_pkg;

  localparam int unsigned MAX_BUCKETS = 1024;
  localparam int unsigned BKT_W       = $clog2(MAX_BUCKETS);
  localparam int unsigned SIZE_W      = 11;
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned CNT_W       = 16;
  localparam int unsigned TOT_W       = 32;
  localparam int unsigned STEP_W      = $clog2(KEY_W);

  localparam logic [KEY_W-1:0] KNUTH_MULT = 32'h9E37_79B9;
  localparam logic [CNT_W-1:0] COUNT_MAX  = {CNT_W{1'b1}};
  localparam logic [TOT_W-1:0] TOTAL_MAX  = {TOT_W{1'b1}};

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 1'b1;

  // Hash unit sequencer
  typedef enum logic [2:0] {
    H_IDLE,
    H_DIV,
    H_FIX,
    H_MUL_FRAC,
    H_MUL_SCALE
  } hstate_e;

  // Top-level sequencer
  typedef enum logic [2:0] {
    T_CLEAR,
    T_IDLE,
    T_HASH,
    T_RD_FIRST,
    T_RD_SECOND,
    T_UPDATE
  } tstate_e;

  // Both candidate buckets, valid for one cycle
  typedef struct packed {
    logic             valid;
    logic [BKT_W-1:0] first;
    logic [BKT_W-1:0] second;
  } hash_res_t;

endpackage
`default_nettype wire

// File: rtl/tcbb_hash.sv
// Iterative hash unit: serial modulo of a signed key and the multiplicative bucket.
`timescale 1ns / 1ps
`default_nettype none
module tcbb_hash (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [tcbb_pkg::KEY_W-1:0]   key_i,
  input  logic [tcbb_pkg::SIZE_W-1:0]  size_i,
  output tcbb_pkg::hash_res_t          res_o
);
  import tcbb_pkg::*;

  hstate_e           hst_q, hst_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [SIZE_W-1:0] size_q, size_d;
  logic [KEY_W-1:0]  mag_q, mag_d;
  logic [BKT_W-1:0]  rem_q, rem_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [KEY_W-1:0]  frac_q, frac_d;
  logic [BKT_W-1:0]  first_q, first_d;
  logic [BKT_W-1:0]  second_q, second_d;
  logic              valid_q, valid_d;

  logic [SIZE_W-1:0]  trial;
  logic [SIZE_W-1:0]  diff;
  logic [KEY_W-1:0]   mul_a;
  logic [KEY_W-1:0]   mul_b;
  logic [2*KEY_W-1:0] prod;

  // Shared datapath: one restoring-division step and one multiplier
  assign trial = {rem_q, mag_q[KEY_W-1]};
  assign diff  = trial - size_q;
  assign prod  = {{KEY_W{1'b0}}, mul_a} * {{KEY_W{1'b0}}, mul_b};

  always_comb begin
    hst_d    = hst_q;
    key_d    = key_q;
    size_d   = size_q;
    mag_d    = mag_q;
    rem_d    = rem_q;
    step_d   = step_q;
    frac_d   = frac_q;
    first_d  = first_q;
    second_d = second_q;
    valid_d  = 1'b0;
    mul_a    = key_q;
    mul_b    = KNUTH_MULT;
    case (hst_q)
      H_IDLE: begin
        if (start_i) begin
          key_d  = key_i;
          size_d = size_i;
          mag_d  = key_i[KEY_W-1] ? (~key_i + 1'b1) : key_i;
          rem_d  = '0;
          step_d = '0;
          hst_d  = H_DIV;
        end
      end
      H_DIV: begin
        rem_d  = (trial >= size_q) ? diff[BKT_W-1:0] : trial[BKT_W-1:0];
        mag_d  = {mag_q[KEY_W-2:0], 1'b0};
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(KEY_W - 1)) begin
          hst_d = H_FIX;
        end
      end
      H_FIX: begin
        // fold a negative remainder back into range
        if (key_q[KEY_W-1] && (rem_q != '0)) begin
          first_d = BKT_W'(size_q - {1'b0, rem_q});
        end else begin
          first_d = rem_q;
        end
        hst_d = H_MUL_FRAC;
      end
      H_MUL_FRAC: begin
        mul_a  = key_q;
        mul_b  = KNUTH_MULT;
        frac_d = prod[KEY_W-1:0];
        hst_d  = H_MUL_SCALE;
      end
      H_MUL_SCALE: begin
        mul_a    = frac_q;
        mul_b    = KEY_W'(size_q);
        second_d = prod[KEY_W +: BKT_W];
        valid_d  = 1'b1;
        hst_d    = H_IDLE;
      end
      default: begin
        hst_d = H_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hst_q   <= H_IDLE;
      valid_q <= 1'b0;
      step_q  <= '0;
    end else begin
      hst_q   <= hst_d;
      valid_q <= valid_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    size_q   <= size_d;
    mag_q    <= mag_d;
    rem_q    <= rem_d;
    frac_q   <= frac_d;
    first_q  <= first_d;
    second_q <= second_d;
  end

  assign res_o.valid  = valid_q;
  assign res_o.first  = first_q;
  assign res_o.second = second_q;

endmodule
`default_nettype wire

// File: rtl/two_choice_bucket_balancer_unit.sv
// Top level of the two-choice bucket balancer: sequencer, occupancy memory, statistics.
//
//  channel  | signals                                   | handshake
//  ---------+-------------------------------------------+-------------------------------
//  request  | start_i, key_i                            | taken when start_i && !busy_o
//  result   | done_o, bucket_o, bucket_count_o,         | valid one cycle while done_o
//           | max_chain_o, total_keys_o                 | is high, cannot be held off
//  config   | cfg_we_i, cfg_idx_i, cfg_wdata_i          | written at every edge with we
//
// One request runs from the accepting edge to the edge that takes its result through the
// serial modulo in the hash unit (one quotient bit per cycle), the fold step H_FIX, the
// multiplier steps H_MUL_FRAC and H_MUL_SCALE, the pick-up of the hash, two reads of the
// occupancy memory, the update step and the cycle in which the result is shown. busy_o
// drops in that last cycle, so no new request is taken before the last result is shown.
// After reset the block clears the 1024-entry occupancy memory, one entry per cycle,
// and holds busy_o high until the sweep is done; configuration writes are still taken.
// The result side never stalls: each result is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
module two_choice_bucket_balancer_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // request
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic signed [tcbb_pkg::KEY_W-1:0] key_i,
  // result
  output logic                            done_o,
  output logic [tcbb_pkg::BKT_W-1:0]      bucket_o,
  output logic [tcbb_pkg::CNT_W-1:0]      bucket_count_o,
  output logic [tcbb_pkg::CNT_W-1:0]      max_chain_o,
  output logic [tcbb_pkg::TOT_W-1:0]      total_keys_o,
  // configuration
  input  logic                            cfg_we_i,
  input  logic [tcbb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tcbb_pkg::SIZE_W-1:0]     cfg_wdata_i
);
  import tcbb_pkg::*;

  tstate_e           tst_q, tst_d;
  logic [SIZE_W-1:0] table_size_q;
  logic              mode_q;
  logic [BKT_W-1:0]  clr_q, clr_d;
  logic [BKT_W-1:0]  first_q, first_d;
  logic [BKT_W-1:0]  second_q, second_d;
  logic [CNT_W-1:0]  occ_first_q, occ_first_d;
  logic [CNT_W-1:0]  rdata_q;

  logic              done_q, done_d;
  logic [BKT_W-1:0]  bucket_q, bucket_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  max_q, max_d;
  logic [TOT_W-1:0]  total_q, total_d;

  logic              accept;
  logic [SIZE_W-1:0] eff_size;
  hash_res_t         hres;

  // occupancy memory port controls
  logic              mem_we;
  logic [BKT_W-1:0]  mem_waddr;
  logic [CNT_W-1:0]  mem_wdata;
  logic              mem_re;
  logic [BKT_W-1:0]  mem_raddr;
  logic [CNT_W-1:0]  occ_mem [MAX_BUCKETS];

  // update-cycle selection
  logic              use_second;
  logic [BKT_W-1:0]  chosen;
  logic [CNT_W-1:0]  cur_cnt;
  logic [CNT_W-1:0]  new_cnt;

  assign busy_o = (tst_q != T_IDLE);
  assign accept = start_i && !busy_o;

  // Clamp the configured size into 1..MAX_BUCKETS
  always_comb begin
    if (table_size_q == '0) begin
      eff_size = SIZE_W'(1);
    end else if (table_size_q > SIZE_W'(MAX_BUCKETS)) begin
      eff_size = SIZE_W'(MAX_BUCKETS);
    end else begin
      eff_size = table_size_q;
    end
  end

  tcbb_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .key_i   (key_i),
    .size_i  (eff_size),
    .res_o   (hres)
  );

  // Ties and single mode go to the modulo bucket
  assign use_second = mode_q && (rdata_q < occ_first_q);
  assign chosen     = use_second ? second_q : first_q;
  assign cur_cnt    = use_second ? rdata_q : occ_first_q;
  assign new_cnt    = (cur_cnt == COUNT_MAX) ? cur_cnt : (cur_cnt + 1'b1);

  always_comb begin
    tst_d       = tst_q;
    clr_d       = clr_q;
    first_d     = first_q;
    second_d    = second_q;
    occ_first_d = occ_first_q;
    done_d      = 1'b0;
    bucket_d    = bucket_q;
    count_d     = count_q;
    max_d       = max_q;
    total_d     = total_q;
    mem_we      = 1'b0;
    mem_waddr   = chosen;
    mem_wdata   = new_cnt;
    mem_re      = 1'b0;
    mem_raddr   = first_q;
    case (tst_q)
      T_CLEAR: begin
        // sweep zeros through the occupancy memory
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == {BKT_W{1'b1}}) begin
          tst_d = T_IDLE;
        end
      end
      T_IDLE: begin
        if (accept) begin
          tst_d = T_HASH;
        end
      end
      T_HASH: begin
        if (hres.valid) begin
          first_d  = hres.first;
          second_d = hres.second;
          tst_d    = T_RD_FIRST;
        end
      end
      T_RD_FIRST: begin
        mem_re    = 1'b1;
        mem_raddr = first_q;
        tst_d     = T_RD_SECOND;
      end
      T_RD_SECOND: begin
        occ_first_d = rdata_q;
        mem_re      = 1'b1;
        mem_raddr   = second_q;
        tst_d       = T_UPDATE;
      end
      T_UPDATE: begin
        // write back the new count and advance the statistics
        mem_we   = 1'b1;
        bucket_d = chosen;
        count_d  = new_cnt;
        max_d    = (new_cnt > max_q) ? new_cnt : max_q;
        total_d  = (total_q == TOTAL_MAX) ? total_q : (total_q + 1'b1);
        done_d   = 1'b1;
        tst_d    = T_IDLE;
      end
      default: begin
        tst_d = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tst_q   <= T_CLEAR;
      clr_q   <= '0;
      done_q  <= 1'b0;
      max_q   <= '0;
      total_q <= '0;
    end else begin
      tst_q   <= tst_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
      max_q   <= max_d;
      total_q <= total_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= SIZE_W'(MAX_BUCKETS);
      mode_q       <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TABLE_SIZE: begin
          table_size_q <= cfg_wdata_i;
        end
        CFG_MODE: begin
          mode_q <= cfg_wdata_i[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    first_q     <= first_d;
    second_q    <= second_d;
    occ_first_q <= occ_first_d;
    bucket_q    <= bucket_d;
    count_q     <= count_d;
  end

  // Occupancy memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      occ_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= occ_mem[mem_raddr];
    end
  end

  assign done_o         = done_q;
  assign bucket_o       = bucket_q;
  assign bucket_count_o = count_q;
  assign max_chain_o    = max_q;
  assign total_keys_o   = total_q;

endmodule
`default_nettype wire

// File: rtl/tcbb_checker.sv
// Port-level checks for the two-choice bucket balancer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module tcbb_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start_i,
  input logic                            busy_o,
  input logic                            done_o,
  input logic [tcbb_pkg::CNT_W-1:0]      bucket_count_o,
  input logic [tcbb_pkg::CNT_W-1:0]      max_chain_o,
  input logic [tcbb_pkg::TOT_W-1:0]      total_keys_o
);
  import tcbb_pkg::*;

  // an accepted request keeps the block busy next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("request accepted but block not busy");

  // results never come back to back
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for two cycles");

  // a placed key's bucket count is nonzero and bounded by the maximum chain, and the key total is nonzero
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (bucket_count_o != '0) && (bucket_count_o <= max_chain_o)
               && (total_keys_o != '0))
    else $error("result statistics inconsistent");

  // the maximum chain never shrinks
  a_max_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    max_chain_o >= $past(max_chain_o))
    else $error("max chain decreased");

  // the key total changes only with a result
  a_total_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o |-> $stable(total_keys_o))
    else $error("key total moved without a result");

endmodule

bind two_choice_bucket_balancer_unit tcbb_checker u_tcbb_checker (.*);
`default_nettype wire
